### rtl/core/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies; compiled first

package deq_pkg;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // request command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_LIST       = 3'd4
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      DP_NONE,
      DP_PUSH_FRONT,
      DP_PUSH_BACK,
      DP_POP_FRONT,
      DP_POP_BACK,
      DP_STATUS,
      DP_ENTRY
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;
      logic list_last;
   } dp_status_type;

endpackage

### rtl/core/deq_channel_if.sv
// valid/ready channel interfaces for requests and responses
// depends on deq_pkg

interface deq_req_if;
   logic                              valid;
   logic                              ready;
   logic [deq_pkg::CMD_W-1:0]         command;
   logic signed [deq_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface deq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [deq_pkg::VALUE_W-1:0] item_value;
   logic [deq_pkg::STATUS_W-1:0]       status;
   logic                               last;

   modport source (output valid, output item_value, output status, output last,
                   input ready);
   modport sink   (input valid, input item_value, input status, input last,
                   output ready);
endinterface

### rtl/core/deq_ctrl.sv
// controller state machine for the double-ended queue
// depends on deq_pkg; drives deq_dp through dp_cmd_type

module deq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [deq_pkg::CMD_W-1:0] req_command,
   output logic                      req_ready,
   input  deq_pkg::dp_status_type    dp_status,
   output deq_pkg::dp_cmd_type       dp_cmd
);

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      dp_cmd.op     = deq_pkg::DP_NONE;
      dp_cmd.status = deq_pkg::STATUS_OK;
      req_ready     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset && dp_status.out_free;
            if (req_valid && req_ready) begin
               case (deq_pkg::cmd_type'(req_command))
                  deq_pkg::CMD_PUSH_FRONT: begin
                     if (dp_status.full) begin
                        dp_cmd.op     = deq_pkg::DP_STATUS;
                        dp_cmd.status = deq_pkg::STATUS_FULL;
                     end else begin
                        dp_cmd.op = deq_pkg::DP_PUSH_FRONT;
                     end
                  end
                  deq_pkg::CMD_PUSH_BACK: begin
                     if (dp_status.full) begin
                        dp_cmd.op     = deq_pkg::DP_STATUS;
                        dp_cmd.status = deq_pkg::STATUS_FULL;
                     end else begin
                        dp_cmd.op = deq_pkg::DP_PUSH_BACK;
                     end
                  end
                  deq_pkg::CMD_POP_FRONT: begin
                     if (dp_status.empty) begin
                        dp_cmd.op     = deq_pkg::DP_STATUS;
                        dp_cmd.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        dp_cmd.op = deq_pkg::DP_POP_FRONT;
                     end
                  end
                  deq_pkg::CMD_POP_BACK: begin
                     if (dp_status.empty) begin
                        dp_cmd.op     = deq_pkg::DP_STATUS;
                        dp_cmd.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        dp_cmd.op = deq_pkg::DP_POP_BACK;
                     end
                  end
                  deq_pkg::CMD_LIST: begin
                     if (dp_status.empty) begin
                        dp_cmd.op     = deq_pkg::DP_STATUS;
                        dp_cmd.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  default: ; // unknown command, dropped silently
               endcase
            end
         end
         S_LIST: begin
            if (dp_status.out_free) begin
               dp_cmd.op = deq_pkg::DP_ENTRY;
               if (dp_status.list_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a list walk only runs over a non-empty queue
   a_list_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> !dp_status.empty)
      else $error("list walk over empty queue");

   // no request is taken while a list walk is in progress
   a_no_accept_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> !req_ready)
      else $error("request accepted during list walk");

   // the walk ends right after its last entry is issued
   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST && dp_cmd.op == deq_pkg::DP_ENTRY && dp_status.list_last)
      |=> (state_ff == S_IDLE))
      else $error("list walk did not end after last entry");

endmodule

### rtl/core/deq_dp.sv
// datapath: ring storage, front pointer, count, list cursor, response register
// depends on deq_pkg and deq_channel_if; commanded by deq_ctrl

module deq_dp #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [deq_pkg::VALUE_W-1:0] push_value,
   input  deq_pkg::dp_cmd_type                dp_cmd,
   output deq_pkg::dp_status_type             dp_status,
   deq_rsp_if.source                          rsp
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic signed [deq_pkg::VALUE_W-1:0] entry_mem [DEPTH];
   logic signed [deq_pkg::VALUE_W-1:0] rd_data_ff;

   logic [PTR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] pos_plus;
   logic [PTR_W-1:0] front_dec, front_inc;
   logic [PTR_W-1:0] wr_addr, rd_addr;
   logic             wr_en;
   logic             load, load_entry;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [deq_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [deq_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic                               rsp_last_ff;

   // ring slot at offset pos from the front
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                input logic [CNT_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(front) + SUM_W'(pos);
      if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
      return sum[PTR_W-1:0];
   endfunction

   assign front_dec = (front_ff == '0) ? PTR_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == PTR_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign pos_plus  = pos_ff + 1'b1;

   assign dp_status.empty     = (count_ff == '0);
   assign dp_status.full      = (count_ff == CNT_W'(DEPTH));
   assign dp_status.out_free  = !rsp_valid_ff || rsp.ready;
   assign dp_status.list_last = (pos_plus == count_ff);

   assign load       = (dp_cmd.op != deq_pkg::DP_NONE);
   assign load_entry = (dp_cmd.op == deq_pkg::DP_ENTRY);

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      case (dp_cmd.op)
         deq_pkg::DP_PUSH_FRONT: begin
            wr_en    = 1'b1;
            wr_addr  = front_dec;
            front_in = front_dec;
            count_in = count_ff + 1'b1;
         end
         deq_pkg::DP_PUSH_BACK: begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(front_ff, count_ff);
            count_in = count_ff + 1'b1;
         end
         deq_pkg::DP_POP_FRONT: begin
            front_in = front_inc;
            count_in = count_ff - 1'b1;
         end
         deq_pkg::DP_POP_BACK: begin
            count_in = count_ff - 1'b1;
         end
         deq_pkg::DP_ENTRY: begin
            pos_in = dp_status.list_last ? '0 : pos_plus;
         end
         default: ;
      endcase
   end

   // read one slot ahead so the next entry is ready when the current one leaves
   assign rd_addr = slot_of(front_ff, pos_in);

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= push_value;
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff  <= load_entry ? rd_data_ff : '0;
         rsp_status_ff <= load_entry ? deq_pkg::STATUS_OK : dp_cmd.status;
         rsp_last_ff   <= load_entry ? dp_status.list_last : 1'b1;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.item_value = rsp_value_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.last       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == deq_pkg::DP_PUSH_FRONT || dp_cmd.op == deq_pkg::DP_PUSH_BACK)
      |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("push did not grow the queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == deq_pkg::DP_POP_FRONT || dp_cmd.op == deq_pkg::DP_POP_BACK)
      |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("pop did not shrink the queue");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> dp_status.out_free)
      else $error("response register overwritten while stalled");

endmodule

### rtl/core/double_ended_queue.sv
// top level of the bounded double-ended queue
// depends on deq_pkg, deq_channel_if, deq_ctrl and deq_dp

// Bounded deque of DEPTH signed 32-bit values kept in a ring memory with a
// front pointer and an entry count. Each request transaction carries one
// command: push front, push back, pop front, pop back or list. Push and pop
// return one response transaction with status ok, empty (pop on an empty
// queue, nothing changes) or full (push on a full queue, value dropped);
// item_value is zero and last is set. List returns every entry from front to
// back with status ok and last on the back entry, or a single empty status.
// Unknown command codes are consumed with no response. Push and pop can
// follow one another every cycle while responses drain. A list holds off
// new requests until its back entry is issued: the walk starts, then reads
// the entries from front to back, paced by the single registered read port
// of the entry memory; a stalled response channel stretches this. A
// request is taken only while the response register is empty or its
// transaction leaves in the same cycle. The memory needs no clearing after
// reset, since only written slots are ever listed.

module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   deq_pkg::dp_cmd_type    dp_cmd;
   deq_pkg::dp_status_type dp_status;

   // sequencing: command decode and list walk
   deq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .dp_status   (dp_status),
      .dp_cmd      (dp_cmd)
   );

   // storage, pointers and response register
   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .push_value (req_chan.push_value),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp        (rsp_chan)
   );

endmodule
